/* rtl/dnsqr_pkg.sv */
package dnsqr_pkg;

   // table geometry
   localparam int unsigned TABLE_ENTRIES_DEFAULT = 256;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_EXPIRY        = 2'd0;
   localparam logic [1:0] REG_QUERY_LIMIT   = 2'd1;
   localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd2;

   localparam logic [31:0] EXPIRY_RESET        = 32'd10;
   localparam logic [15:0] QUERY_LIMIT_RESET   = 16'd10;
   localparam logic [31:0] PAYLOAD_LIMIT_RESET = 32'd100;

   // protocol constants
   localparam logic [15:0] DNS_PORT         = 16'd53;
   localparam logic [31:0] UDP_HEADER_BYTES = 32'd8;

   // saturation limits
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [8:0]  REMOVED_MAX = 9'h1FF;

   localparam int unsigned SRC_W = 32;

   typedef enum logic [0:0] {
      ACTION_PACKET = 1'b0,
      ACTION_SWEEP  = 1'b1
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] src_ip;
      logic [15:0] dst_port;
      logic [15:0] ip_total_length;
      logic [3:0]  ip_header_words;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic       tagged_res;
      logic       suspicious;
      logic       new_source;
      logic       slot_conflict;
      logic [8:0] removed_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] source;
      logic [15:0] count;
      logic [31:0] created;
   } entry_type;

endpackage

/* rtl/dnsqr_table_ram.sv */
module dnsqr_table_ram #(
   parameter int unsigned DEPTH = dnsqr_pkg::TABLE_ENTRIES_DEFAULT,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  dnsqr_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output dnsqr_pkg::entry_type rd_data
);
   import dnsqr_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dns_source_query_rate_detector_core.sv */
// channel  | direction | handshake              | word
// ---------+-----------+------------------------+------------------------------------
// req      | in        | req_valid / req_stall  | req_data: packet header or sweep tick
// rsp      | out       | rsp_valid / rsp_stall  | rsp_data: flags and removed count
// csr      | in / out  | apb, pready tied high  | expiry, query limit, payload limit
//
// a counted packet word is accepted with its table read issued, then evaluated and written back,
// when TABLE_ENTRIES is a power of two; otherwise a slot remainder pass, 8 bits of the source
// each step, comes between; a packet that is not counted goes from accept straight to evaluate
// a sweep tick is accepted, then takes one read per entry, one trailing check of the last
// entry, then the result load
// after reset a clearing pass empties every table entry, req_stall held high
// a finished word sits in the rsp register; the next req word is taken meanwhile and only
// its final cycle waits while rsp_stall holds the previous word
module dns_source_query_rate_detector_core #(
   parameter int unsigned TABLE_ENTRIES = dnsqr_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dnsqr_pkg::req_type              req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dnsqr_pkg::rsp_type              rsp_data,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dnsqr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import dnsqr_pkg::*;

   localparam int unsigned AW        = $clog2(TABLE_ENTRIES);
   localparam int unsigned RW        = AW + 1;          // remainder before reduction
   localparam bit          IS_POW2   = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
   localparam int unsigned MOD_BITS  = 8;               // source bits folded per cycle
   localparam int unsigned MOD_STEPS = SRC_W / MOD_BITS;
   localparam int unsigned MOD_CW    = $clog2(MOD_STEPS);
   localparam logic [MOD_CW-1:0] MOD_LAST = MOD_CW'(MOD_STEPS - 1);
   localparam logic [AW-1:0]     IDX_LAST = AW'(TABLE_ENTRIES - 1);
   localparam logic [RW-1:0]     MODULUS  = RW'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_EVAL,
      ST_SWEEP,
      ST_SWEEP_OUT
   } state_type;

   // configuration registers
   logic [31:0] expiry_ff;
   logic [15:0] query_limit_ff;
   logic [31:0] payload_limit_ff;

   // control and item registers
   state_type      state_ff;
   logic [AW-1:0]  idx_ff;
   logic [AW-1:0]  slot_ff;
   logic [AW-1:0]  chk_addr_ff;
   logic           chk_ff;
   logic           last_issued_ff;
   logic [8:0]     removed_ff;
   logic [31:0]    src_ff;
   logic [31:0]    now_ff;
   logic [31:0]    limit_time_ff;
   logic           counted_ff;
   logic [RW-1:0]  mod_rem_ff;
   logic [SRC_W-1:0] mod_src_ff;
   logic [MOD_CW-1:0] mod_cnt_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   // combinational
   logic           req_accept;
   logic           out_free;
   logic           rsp_load;
   logic [31:0]    udp_data_len;
   logic           counted;
   logic [RW-1:0]  mod_rem_in;
   entry_type      ent;
   logic           hit;
   logic [15:0]    cnt_inc;
   logic           over;
   logic           expire;
   rsp_type        eval_rsp;
   rsp_type        sweep_rsp;

   // table port
   logic           tbl_wr_en;
   logic [AW-1:0]  tbl_wr_addr;
   entry_type      tbl_wr_data;
   logic           tbl_rd_en;
   logic [AW-1:0]  tbl_rd_addr;

   dnsqr_table_ram #(
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (ent)
   );

   // ------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff        <= EXPIRY_RESET;
         query_limit_ff   <= QUERY_LIMIT_RESET;
         payload_limit_ff <= PAYLOAD_LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_EXPIRY:        expiry_ff        <= csr_pwdata;
            REG_QUERY_LIMIT:   query_limit_ff   <= csr_pwdata[15:0];
            REG_PAYLOAD_LIMIT: payload_limit_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_EXPIRY:        csr_prdata = expiry_ff;
         REG_QUERY_LIMIT:   csr_prdata = {16'd0, query_limit_ff};
         REG_PAYLOAD_LIMIT: csr_prdata = payload_limit_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // intake: payload length and dns filter
   // ------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = out_free && (state_ff == ST_EVAL || state_ff == ST_SWEEP_OUT);

   always_comb begin
      // total length minus ip header minus udp header, wrapping
      udp_data_len = 32'(req_data.ip_total_length)
                   - {26'd0, req_data.ip_header_words, 2'b00}
                   - UDP_HEADER_BYTES;
      counted = (req_data.action == ACTION_PACKET)
             && (req_data.dst_port == DNS_PORT)
             && (udp_data_len > payload_limit_ff);
   end

   // slot remainder, one byte of the source per cycle, msb first
   always_comb begin
      logic [RW-1:0] r;
      r = mod_rem_ff;
      for (int k = 0; k < MOD_BITS; k++) begin
         r = {r[RW-2:0], mod_src_ff[SRC_W-1-k]};
         if (r >= MODULUS) begin
            r = r - MODULUS;
         end
      end
      mod_rem_in = r;
   end

   // ------------------------------------------------------------------
   // entry evaluation on registered read data
   // ------------------------------------------------------------------
   always_comb begin
      hit     = ent.valid && (ent.source == src_ff);
      cnt_inc = (ent.count == COUNT_MAX) ? COUNT_MAX : ent.count + 16'd1;
      over    = (cnt_inc > query_limit_ff);
      expire  = ent.valid && (ent.created < limit_time_ff);

      eval_rsp = '0;
      if (counted_ff) begin
         eval_rsp.tagged_res = 1'b1;
         if (!ent.valid) begin
            eval_rsp.new_source = 1'b1;
         end else if (hit) begin
            eval_rsp.suspicious = over;
         end else begin
            eval_rsp.slot_conflict = 1'b1;
         end
      end

      sweep_rsp = '0;
      sweep_rsp.removed_count = removed_ff;
   end

   // table write port
   always_comb begin
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = slot_ff;
      tbl_wr_data = ent;
      case (state_ff)
         ST_CLEAR: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = idx_ff;
            tbl_wr_data = '0;
         end
         ST_EVAL: begin
            if (out_free && counted_ff) begin
               if (!ent.valid) begin
                  // fresh source
                  tbl_wr_en           = 1'b1;
                  tbl_wr_data.valid   = 1'b1;
                  tbl_wr_data.source  = src_ff;
                  tbl_wr_data.count   = 16'd1;
                  tbl_wr_data.created = now_ff;
               end else if (hit) begin
                  tbl_wr_en = 1'b1;
                  if (over) begin
                     tbl_wr_data.valid = 1'b0;
                  end else begin
                     tbl_wr_data.count = cnt_inc;
                  end
               end
            end
         end
         ST_SWEEP: begin
            if (chk_ff && expire) begin
               tbl_wr_en         = 1'b1;
               tbl_wr_addr       = chk_addr_ff;
               tbl_wr_data.valid = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // table read port
   always_comb begin
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (IS_POW2 && req_accept && counted) begin
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = req_data.src_ip[AW-1:0];
            end
         end
         ST_MOD: begin
            if (mod_cnt_ff == MOD_LAST) begin
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = mod_rem_in[AW-1:0];
            end
         end
         ST_SWEEP: begin
            tbl_rd_en = !last_issued_ff;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         idx_ff         <= '0;
         slot_ff        <= '0;
         chk_addr_ff    <= '0;
         chk_ff         <= 1'b0;
         last_issued_ff <= 1'b0;
         removed_ff     <= '0;
         src_ff         <= '0;
         now_ff         <= '0;
         limit_time_ff  <= '0;
         counted_ff     <= 1'b0;
         mod_rem_ff     <= '0;
         mod_src_ff     <= '0;
         mod_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_data_ff    <= '0;
      end else begin
         // load a finished word, or drop the one just taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            // empty the table, one entry a cycle
            ST_CLEAR: begin
               if (idx_ff == IDX_LAST) begin
                  idx_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end

            ST_IDLE: begin
               if (req_accept) begin
                  src_ff        <= req_data.src_ip;
                  now_ff        <= req_data.now_seconds;
                  limit_time_ff <= req_data.now_seconds - expiry_ff;
                  counted_ff    <= counted;
                  if (req_data.action == ACTION_SWEEP) begin
                     idx_ff         <= '0;
                     chk_ff         <= 1'b0;
                     last_issued_ff <= 1'b0;
                     removed_ff     <= '0;
                     state_ff       <= ST_SWEEP;
                  end else if (counted && !IS_POW2) begin
                     mod_rem_ff <= '0;
                     mod_src_ff <= req_data.src_ip;
                     mod_cnt_ff <= '0;
                     state_ff   <= ST_MOD;
                  end else begin
                     // power of two slot, or nothing to look up
                     slot_ff  <= req_data.src_ip[AW-1:0];
                     state_ff <= ST_EVAL;
                  end
               end
            end

            ST_MOD: begin
               mod_rem_ff <= mod_rem_in;
               mod_src_ff <= mod_src_ff << MOD_BITS;
               mod_cnt_ff <= mod_cnt_ff + 1'b1;
               if (mod_cnt_ff == MOD_LAST) begin
                  slot_ff  <= mod_rem_in[AW-1:0];
                  state_ff <= ST_EVAL;
               end
            end

            // read data valid here; write back and respond together
            ST_EVAL: begin
               if (out_free) begin
                  rsp_data_ff <= eval_rsp;
                  state_ff    <= ST_IDLE;
               end
            end

            // read entry i while checking entry i-1
            ST_SWEEP: begin
               chk_ff      <= !last_issued_ff;
               chk_addr_ff <= idx_ff;
               if (!last_issued_ff) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (idx_ff == IDX_LAST) begin
                     last_issued_ff <= 1'b1;
                  end
               end
               if (chk_ff && expire && (removed_ff != REMOVED_MAX)) begin
                  removed_ff <= removed_ff + 1'b1;
               end
               if (last_issued_ff) begin
                  state_ff <= ST_SWEEP_OUT;
               end
            end

            ST_SWEEP_OUT: begin
               if (out_free) begin
                  rsp_data_ff <= sweep_rsp;
                  state_ff    <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_EVAL || state_ff == ST_SWEEP))
      else $error("table written outside clear, evaluate or sweep");

   a_sweep_only_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && tbl_wr_en) |-> !tbl_wr_data.valid)
      else $error("sweep wrote a valid entry");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.tagged_res && (rsp_data_ff.removed_count != '0)))
      else $error("response mixes packet and sweep results");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones({rsp_data_ff.suspicious, rsp_data_ff.new_source,
                                    rsp_data_ff.slot_conflict}) <= 1))
      else $error("more than one table outcome");

   a_outcome_tagged: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.suspicious || rsp_data_ff.new_source
                        || rsp_data_ff.slot_conflict)) |-> rsp_data_ff.tagged_res)
      else $error("table outcome on untagged packet");
`endif

endmodule
